@@ rtl/iira_pkg.sv @@
`default_nettype none
package iira_pkg;

	localparam int CAPACITY_DEF = 256;

	localparam int REQ_W = 2;
	localparam int POS_W = 8;
	localparam int WORD_W = 32;
	localparam int CNT_OUT_W = 9;
	localparam int ST_W = 2;

	localparam logic [REQ_W-1:0] REQ_READ = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef logic [REQ_W-1:0] req_type_t;
	typedef logic [POS_W-1:0] position_t;
	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [CNT_OUT_W-1:0] count_out_t;
	typedef logic [ST_W-1:0] status_t;

	// memory port strobes from the sequencer
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ram_ctl_t;

endpackage
`default_nettype wire

@@ rtl/iira_req_if.sv @@
`default_nettype none
interface iira_req_if;
	import iira_pkg::*;

	logic valid;
	logic ready;
	req_type_t req_type;
	position_t position;
	word_t new_word;

	modport source (output valid, output req_type, output position, output new_word,
		input ready);
	modport sink (input valid, input req_type, input position, input new_word,
		output ready);
endinterface
`default_nettype wire

@@ rtl/iira_rsp_if.sv @@
`default_nettype none
interface iira_rsp_if;
	import iira_pkg::*;

	logic valid;
	logic ready;
	word_t read_word;
	count_out_t element_count;
	status_t status;

	modport source (output valid, output read_word, output element_count, output status,
		input ready);
	modport sink (input valid, input read_word, input element_count, input status,
		output ready);
endinterface
`default_nettype wire

@@ rtl/indexed_insert_remove_array.sv @@
`default_nettype none
// Ordered array of signed 32-bit words with indexed read, insert and remove.
// Every request transaction on req yields exactly one response transaction on rsp
// with the word read (zero unless a good read), the element count after the request
// and a status (ok, position out of range, array full on insert). A rejected request
// leaves the array as it was. The words live in a single simple dual-port RAM of
// CAPACITY entries with a registered read; an insert or remove moves the higher
// entries one slot per cycle, reading one entry ahead and writing the entry read
// the cycle before. An insert or remove takes longer the more entries lie above
// its position, set by the one shift per cycle the RAM ports allow. One request
// is in flight at a time; req.ready is high whenever the sequencer is idle, also
// while the previous response still waits in its output register. There is no
// clearing pass after reset: only entries below the count are ever read, and each
// was written.
module indexed_insert_remove_array #(
	parameter int CAPACITY = iira_pkg::CAPACITY_DEF
) (
	input wire          clk,
	input wire          arst_n,
	iira_req_if.sink    req,
	iira_rsp_if.source  rsp
);
	import iira_pkg::*;

	localparam int AW = $clog2(CAPACITY);

	ram_ctl_t ram_ctl;
	logic [AW-1:0] ram_waddr;
	logic [AW-1:0] ram_raddr;
	word_t ram_wdata;
	word_t ram_rdata;

	// sequencer: request decode, count, shift walk and response register
	iira_ctrl #(
		.CAPACITY(CAPACITY),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.ram_ctl(ram_ctl),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// word store
	iira_ram #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.ctl(ram_ctl),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

`ifndef NO_ASSERTIONS
	// the shift walk never reads the slot it writes in the same cycle
	a_no_rw_same: assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.wr_en && ram_ctl.rd_en |-> ram_waddr != ram_raddr)
		else $error("ram read and write hit the same entry");

	// one request at a time: an accepted transaction takes the sequencer busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while a previous one is in flight");

	// the store is only written while a request is being worked on
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.wr_en |-> !req.ready)
		else $error("ram written while idle");

	// a full status goes with a full count
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_FULL |-> rsp.element_count == CNT_OUT_W'(CAPACITY))
		else $error("full status with a count below capacity");
`endif
endmodule
`default_nettype wire

@@ rtl/iira_ram.sv @@
`default_nettype none
module iira_ram #(
	parameter int DEPTH = iira_pkg::CAPACITY_DEF,
	parameter int AW = $clog2(DEPTH)
) (
	input  wire                       clk,
	input  wire iira_pkg::ram_ctl_t   ctl,
	input  wire  [AW-1:0]             waddr,
	input  wire iira_pkg::word_t      wdata,
	input  wire  [AW-1:0]             raddr,
	output iira_pkg::word_t           rdata
);
	import iira_pkg::*;

	word_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

@@ rtl/iira_ctrl.sv @@
`default_nettype none
module iira_ctrl #(
	parameter int CAPACITY = iira_pkg::CAPACITY_DEF,
	parameter int AW = $clog2(CAPACITY)
) (
	input  wire                  clk,
	input  wire                  arst_n,
	iira_req_if.sink             req,
	iira_rsp_if.source           rsp,
	output iira_pkg::ram_ctl_t   ram_ctl,
	output logic [AW-1:0]        ram_waddr,
	output iira_pkg::word_t      ram_wdata,
	output logic [AW-1:0]        ram_raddr,
	input  wire iira_pkg::word_t ram_rdata
);
	import iira_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_INSW = 3'd3;
	localparam logic [2:0] S_FIN = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic out_valid_q;

	logic [AW-1:0] pos_q;
	word_t word_q;
	logic up_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] end_q;
	word_t res_word_q;
	status_t res_st_q;
	word_t read_word_q;
	count_out_t element_q;
	status_t status_q;

	logic accept;
	logic out_load;
	logic [CMPW-1:0] pos_x;
	logic [CMPW-1:0] cnt_x;
	logic [AW-1:0] pos_a;
	logic [AW-1:0] pos_a_inc;
	logic [AW-1:0] cnt_dec_a;
	logic in_range;
	logic ins_range_err;
	logic is_full;
	logic is_last;
	status_t st_d;
	logic shift_last;

	assign req.ready = (state_q == S_IDLE);
	assign accept = req.valid && req.ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || rsp.ready);

	assign rsp.valid = out_valid_q;
	assign rsp.read_word = read_word_q;
	assign rsp.element_count = element_q;
	assign rsp.status = status_q;

	always_comb begin
		pos_x = CMPW'(req.position);
		cnt_x = CMPW'(count_q);
		pos_a = AW'(req.position);
		pos_a_inc = AW'(pos_a + AW'(1));
		cnt_dec_a = AW'(count_q - CW'(1));
		in_range = pos_x < cnt_x;
		ins_range_err = pos_x > cnt_x;
		is_full = cnt_x >= CMPW'(CAPACITY);
		is_last = CMPW'(pos_x + CMPW'(1)) == cnt_x;
		shift_last = addr_q == end_q;
	end

	// decode of the accepted request and the sequencer's next state
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		st_d = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_FIN;
					case (req.req_type)
						REQ_READ: begin
							if (in_range) begin
								state_d = S_RD;
							end else begin
								st_d = ST_RANGE;
							end
						end
						REQ_INSERT: begin
							if (ins_range_err) begin
								st_d = ST_RANGE;
							end else if (is_full) begin
								st_d = ST_FULL;
							end else begin
								count_d = CW'(count_q + CW'(1));
								state_d = (pos_x == cnt_x) ? S_INSW : S_SHIFT;
							end
						end
						REQ_REMOVE: begin
							if (!in_range) begin
								st_d = ST_RANGE;
							end else begin
								count_d = CW'(count_q - CW'(1));
								state_d = is_last ? S_FIN : S_SHIFT;
							end
						end
						default: begin
							state_d = S_FIN;
						end
					endcase
				end
			end
			S_RD: state_d = S_FIN;
			S_SHIFT: begin
				if (shift_last) begin
					state_d = up_q ? S_INSW : S_FIN;
				end
			end
			S_INSW: state_d = S_FIN;
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory port: read one entry ahead, write it back one slot over the next cycle
	always_comb begin
		ram_ctl = '0;
		ram_waddr = '0;
		ram_wdata = ram_rdata;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (state_d == S_RD) begin
					ram_ctl.rd_en = 1'b1;
					ram_raddr = pos_a;
				end else if (state_d == S_SHIFT) begin
					ram_ctl.rd_en = 1'b1;
					ram_raddr = (req.req_type == REQ_INSERT) ? cnt_dec_a : pos_a_inc;
				end
			end
			S_SHIFT: begin
				ram_ctl.wr_en = 1'b1;
				ram_waddr = up_q ? AW'(addr_q + AW'(1)) : AW'(addr_q - AW'(1));
				if (!shift_last) begin
					ram_ctl.rd_en = 1'b1;
					ram_raddr = up_q ? AW'(addr_q - AW'(1)) : AW'(addr_q + AW'(1));
				end
			end
			S_INSW: begin
				ram_ctl.wr_en = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = word_q;
			end
			default: begin
				ram_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q <= pos_a;
			word_q <= req.new_word;
			res_word_q <= '0;
			res_st_q <= st_d;
			up_q <= (req.req_type == REQ_INSERT);
			if (req.req_type == REQ_INSERT) begin
				addr_q <= cnt_dec_a;
				end_q <= pos_a;
			end else begin
				addr_q <= pos_a_inc;
				end_q <= cnt_dec_a;
			end
		end
		if (state_q == S_RD) begin
			res_word_q <= ram_rdata;
		end
		if (state_q == S_SHIFT && !shift_last) begin
			addr_q <= up_q ? AW'(addr_q - AW'(1)) : AW'(addr_q + AW'(1));
		end
		if (out_load) begin
			read_word_q <= res_word_q;
			element_q <= CNT_OUT_W'(count_q);
			status_q <= res_st_q;
		end
	end
endmodule
`default_nettype wire
